// ===== design/assert_macros.svh =====
// Assertion macros shared by the camera motion update design.
// Each macro expands to a concurrent assertion, or to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== design/ecmu_pkg.sv =====
// Package for the camera motion update: fixed-point constants and the CORDIC angle table.
// Used by the CORDIC unit and the top level.
package ecmu_pkg;
   localparam int CordicSteps = 16;
   localparam int StepW = $clog2(CordicSteps + 1);
   localparam logic signed [25:0] FullTurn = 26'sd23592960;
   localparam logic signed [25:0] HalfTurn = 26'sd11796480;
   localparam logic signed [25:0] QuarterTurn = 26'sd5898240;
   localparam logic signed [25:0] PitchLimit = 26'sd5832704;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic [23:0] SpeedReset = 24'd655360;
   localparam logic signed [39:0] PosMax = 40'sh7FFFFFFFFF;
   localparam logic signed [39:0] PosMin = 40'sh8000000000;

   function automatic logic signed [22:0] atan_entry(input logic [4:0] i);
      logic signed [22:0] r;
      case (i)
         5'd0: r = 23'sd2949120;  5'd1: r = 23'sd1740967;
         5'd2: r = 23'sd919879;   5'd3: r = 23'sd466945;
         5'd4: r = 23'sd234379;   5'd5: r = 23'sd117304;
         5'd6: r = 23'sd58666;    5'd7: r = 23'sd29335;
         5'd8: r = 23'sd14668;    5'd9: r = 23'sd7334;
         5'd10: r = 23'sd3667;    5'd11: r = 23'sd1833;
         5'd12: r = 23'sd917;     5'd13: r = 23'sd458;
         5'd14: r = 23'sd229;     5'd15: r = 23'sd115;
         5'd16: r = 23'sd57;      5'd17: r = 23'sd29;
         5'd18: r = 23'sd14;      5'd19: r = 23'sd7;
         5'd20: r = 23'sd4;       5'd21: r = 23'sd2;
         5'd22: r = 23'sd1;       default: r = 23'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] clamp_unit(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd16384) r = 16'sd16384;
      else if (v < -36'sd16384) r = -16'sd16384;
      else r = v[15:0];
      return r;
   endfunction
endpackage

// ===== design/ecmu_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sine and cosine in Q1.14.
// Depends on ecmu_pkg for the angle table and gain.
module ecmu_cordic import ecmu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [25:0]  angle,   // 1/65536 degree, -180..360
   output logic                done,
   output logic signed [15:0]  sin_out,
   output logic signed [15:0]  cos_out
);
   typedef enum logic [1:0] {IDLE, ROTATE, FINISH} state_type;
   state_type state_ff;
   logic [StepW-1:0] step_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [26:0] z_ff;
   logic neg_ff;
   logic signed [33:0] x_in, y_in, xs, ys;
   logic signed [26:0] z_in;
   logic signed [25:0] a0, a1;
   logic neg_in;
   logic signed [35:0] xr, yr;

   always_comb begin
      a0 = (angle > HalfTurn) ? angle - FullTurn : angle;
      neg_in = 1'b0;
      a1 = a0;
      if (a0 > QuarterTurn) begin
         a1 = a0 - HalfTurn; neg_in = 1'b1;
      end else if (a0 < -QuarterTurn) begin
         a1 = a0 + HalfTurn; neg_in = 1'b1;
      end
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      if (!z_ff[26]) begin
         x_in = x_ff - ys; y_in = y_ff + xs;
         z_in = z_ff - 27'(atan_entry(5'(step_ff)));
      end else begin
         x_in = x_ff + ys; y_in = y_ff - xs;
         z_in = z_ff + 27'(atan_entry(5'(step_ff)));
      end
      xr = (36'(x_ff) + 36'sd32768) >>> 16;
      yr = (36'(y_ff) + 36'sd32768) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         case (state_ff)
            IDLE: if (start) begin
               x_ff <= CordicGain; y_ff <= '0; z_ff <= 27'(a1);
               neg_ff <= neg_in; step_ff <= '0; state_ff <= ROTATE;
            end
            ROTATE: begin
               x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == StepW'(CordicSteps - 1)) state_ff <= FINISH;
            end
            FINISH: begin
               cos_out <= neg_ff ? -clamp_unit(xr) : clamp_unit(xr);
               sin_out <= neg_ff ? -clamp_unit(yr) : clamp_unit(yr);
               done <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// ===== design/euler_camera_motion_update.sv =====
// Euler-angle fly camera update. Each accepted tick integrates yaw (wrapped to 0..360
// degrees) and pitch (clamped to +-89), derives forward, right and up vectors with a
// shared iterative CORDIC, moves the position along forward and right, and returns one
// result. S_YAW, S_PITCH and S_ANG update the angles. Each of the two CORDIC passes
// runs start, 16 micro-rotations, rounding and hand-back. Thirteen steps go through
// one shared 34x26 multiplier, and S_POS updates the position. The result waits in
// S_OUT until it is taken, and the block then returns to idle. req_tready is low
// while an item is in work or its result awaits transfer. The speed register may be
// written only while idle. Depends on ecmu_pkg, ecmu_cordic and assert_macros.svh.
`include "assert_macros.svh"
module euler_camera_motion_update import ecmu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_step[15:0], yaw_rate[41:16], pitch_rate[67:42], move_forward[85:68],
   // move_side[103:86], zeros [111:104]
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x[39:0], pos_y[79:40], pos_z[119:80], fwd_x..z [167:120],
   // right_x..z [215:168], up_x..z [263:216]
   output logic [263:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [23:0]  csr_data
);
   typedef enum logic [4:0] {
      S_IDLE, S_YAW, S_PITCH, S_ANG, S_CY, S_CYW, S_CP, S_CPW,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
      S_M10, S_M11, S_M12, S_POS, S_OUT
   } state_type;
   state_type state_ff;

   logic [23:0] speed_ff;
   logic [24:0] yaw_ff;
   logic signed [23:0] pitch_ff;
   logic signed [39:0] px_ff, py_ff, pz_ff;
   logic [15:0] dt_ff;
   logic signed [25:0] yr_ff, pr_ff;
   logic signed [17:0] mf_ff, ms_ff;
   logic signed [15:0] sy_ff, cy_ff, sp_ff, cp_ff;
   logic signed [15:0] fx_ff, fz_ff, ux_ff, uz_ff;
   logic signed [33:0] sf_ff, ss_ff;
   logic signed [41:0] dx_ff, dy_ff, dz_ff;
   logic signed [41:0] dyaw_ff, dpitch_ff;

   // Shared multiplier.
   logic signed [33:0] ma;
   logic signed [25:0] mb;
   logic signed [59:0] prod;
   assign prod = 60'(ma) * 60'(mb);

   logic cs_start, cs_done;
   logic signed [25:0] cs_angle;
   logic signed [15:0] cs_sin, cs_cos;
   ecmu_cordic u_cordic (.clock, .reset, .start(cs_start), .angle(cs_angle),
      .done(cs_done), .sin_out(cs_sin), .cos_out(cs_cos));

   assign cs_start = (state_ff == S_CY) || (state_ff == S_CP);
   assign cs_angle = (state_ff == S_CY) ? 26'($signed({1'b0, yaw_ff})) : 26'(pitch_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign csr_ready = 1'b1;

   always_comb begin
      ma = '0; mb = '0;
      case (state_ff)
         S_YAW:   begin ma = 34'(yr_ff); mb = 26'($signed({1'b0, dt_ff})); end
         S_PITCH: begin ma = 34'(pr_ff); mb = 26'($signed({1'b0, dt_ff})); end
         S_M0, S_M1: begin ma = 34'(state_ff == S_M0 ? mf_ff : ms_ff);
                     mb = 26'($signed({1'b0, speed_ff})); end
         S_M2, S_M3: begin ma = state_ff == S_M2 ? sf_ff : ss_ff;
                     mb = 26'($signed({1'b0, dt_ff})); end
         S_M4:  begin ma = 34'(cy_ff); mb = 26'(cp_ff); end
         S_M5:  begin ma = 34'(sy_ff); mb = 26'(cp_ff); end
         S_M6:  begin ma = 34'(cy_ff); mb = 26'(sp_ff); end
         S_M7:  begin ma = 34'(sy_ff); mb = 26'(sp_ff); end
         S_M8:  begin ma = sf_ff; mb = 26'(fx_ff); end
         S_M9:  begin ma = sf_ff; mb = 26'(sp_ff); end
         S_M10: begin ma = sf_ff; mb = 26'(fz_ff); end
         S_M11: begin ma = ss_ff; mb = -26'(sy_ff); end
         S_M12: begin ma = ss_ff; mb = 26'(cy_ff); end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   logic signed [59:0] r16, r14;
   logic signed [15:0] m14;
   assign r16 = (prod + 60'sd32768) >>> 16;
   assign r14 = (prod + 60'sd8192) >>> 14;
   assign m14 = clamp_unit(36'(r14));

   logic signed [42:0] yaw_sum, yaw_mod;
   logic signed [42:0] pitch_sum;
   logic signed [42:0] nx, ny, nz;
   always_comb begin
      yaw_sum = 43'($signed({1'b0, yaw_ff})) + 43'(dyaw_ff);
      // The delta is below 2^25 in magnitude, so the sum lies within two turns either
      // side of the wrapped range and one of five offsets brings it back.
      if (yaw_sum >= 2 * 43'(FullTurn)) yaw_mod = yaw_sum - 2 * 43'(FullTurn);
      else if (yaw_sum >= 43'(FullTurn)) yaw_mod = yaw_sum - 43'(FullTurn);
      else if (yaw_sum >= 43'sd0) yaw_mod = yaw_sum;
      else if (yaw_sum >= -43'(FullTurn)) yaw_mod = yaw_sum + 43'(FullTurn);
      else yaw_mod = yaw_sum + 2 * 43'(FullTurn);
      pitch_sum = 43'(pitch_ff) + 43'(dpitch_ff);
      nx = 43'(px_ff) + 43'(dx_ff);
      ny = 43'(py_ff) + 43'(dy_ff);
      nz = 43'(pz_ff) + 43'(dz_ff);
   end

   function automatic logic signed [39:0] sat(input logic signed [42:0] v);
      logic signed [39:0] r;
      if (v > 43'(PosMax)) r = PosMax;
      else if (v < 43'(PosMin)) r = PosMin;
      else r = v[39:0];
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         speed_ff <= SpeedReset;
         yaw_ff <= '0; pitch_ff <= '0;
         px_ff <= '0; py_ff <= '0; pz_ff <= '0;
      end else begin
         if (csr_valid) speed_ff <= csr_data;
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               dt_ff <= req_tdata[15:0];
               yr_ff <= req_tdata[41:16];
               pr_ff <= req_tdata[67:42];
               mf_ff <= req_tdata[85:68];
               ms_ff <= req_tdata[103:86];
               state_ff <= S_YAW;
            end
            S_YAW: begin dyaw_ff <= 42'(prod >>> 16); state_ff <= S_PITCH; end
            S_PITCH: begin dpitch_ff <= 42'(prod >>> 16); state_ff <= S_ANG; end
            S_ANG: begin
               yaw_ff <= 25'(yaw_mod);
               if (pitch_sum > 43'(PitchLimit)) pitch_ff <= 24'(PitchLimit);
               else if (pitch_sum < -43'(PitchLimit)) pitch_ff <= -24'(PitchLimit);
               else pitch_ff <= 24'(pitch_sum);
               state_ff <= S_CY;
            end
            S_CY: state_ff <= S_CYW;
            S_CYW: if (cs_done) begin
               sy_ff <= cs_sin; cy_ff <= cs_cos; state_ff <= S_CP;
            end
            S_CP: state_ff <= S_CPW;
            S_CPW: if (cs_done) begin
               sp_ff <= cs_sin; cp_ff <= cs_cos; state_ff <= S_M0;
            end
            S_M0: begin sf_ff <= 34'(r16); state_ff <= S_M1; end
            S_M1: begin ss_ff <= 34'(r16); state_ff <= S_M2; end
            S_M2: begin sf_ff <= 34'(r16); state_ff <= S_M3; end
            S_M3: begin ss_ff <= 34'(r16); state_ff <= S_M4; end
            S_M4: begin fx_ff <= m14; state_ff <= S_M5; end
            S_M5: begin fz_ff <= m14; state_ff <= S_M6; end
            S_M6: begin ux_ff <= -m14; state_ff <= S_M7; end
            S_M7: begin uz_ff <= -m14; state_ff <= S_M8; end
            S_M8: begin dx_ff <= 42'(r14); state_ff <= S_M9; end
            S_M9: begin dy_ff <= 42'(r14); state_ff <= S_M10; end
            S_M10: begin dz_ff <= 42'(r14); state_ff <= S_M11; end
            S_M11: begin dx_ff <= dx_ff + 42'(r14); state_ff <= S_M12; end
            S_M12: begin dz_ff <= dz_ff + 42'(r14); state_ff <= S_POS; end
            S_POS: begin
               px_ff <= sat(nx); py_ff <= sat(ny); pz_ff <= sat(nz);
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {uz_ff, cp_ff, ux_ff, cy_ff, 16'sd0, -sy_ff,
                       fz_ff, sp_ff, fx_ff, pz_ff, py_ff, px_ff};

   `ASSERT_IMPLIES(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_tready)
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_pitch_bounded, clock, reset, 1'b1,
      pitch_ff <= 24'(PitchLimit) && pitch_ff >= -24'(PitchLimit))
endmodule

// ===== sim/euler_camera_motion_update_tb.sv =====
// Self-checking testbench for the Euler-angle fly camera update: directed ticks, then random ones.
// Carries its own fixed-point camera predictor; depends on ecmu_pkg and euler_camera_motion_update.
// Stream ports stall at random, and the speed register is rewritten between phases.
module euler_camera_motion_update_tb;
   import ecmu_pkg::*;

   localparam longint TurnFull    = 23592960;
   localparam longint TurnHalf    = 11796480;
   localparam longint TurnQuarter = 5898240;
   localparam longint PitchClamp  = 5832704;
   localparam longint Gain30      = 652032874;
   localparam longint PosTop      = 64'sd549755813887;
   localparam longint PosBottom   = -64'sd549755813888;
   localparam int     Iterations  = 16;
   localparam int     CycleLimit  = 400000;
   localparam int     RandomPerPhase = 97;
   localparam int     NumDirected = 13;

   localparam longint ArcTable [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   typedef struct packed {
      logic [15:0]        dt;
      logic signed [25:0] yaw_rate;
      logic signed [25:0] pitch_rate;
      logic signed [17:0] fwd_amt;
      logic signed [17:0] side_amt;
   } tick_t;

   typedef struct packed {
      tick_t tick;
      logic  at_origin;   // position is known to stay at the origin
   } tick_row_t;

   typedef struct {
      logic signed [39:0] pos [3];
      logic signed [15:0] vec [9];
   } camera_view_t;

   localparam tick_row_t DIRECTED [NumDirected] = '{
      '{'{16'd0, 26'sd0, 26'sd0, 18'sd0, 18'sd0}, 1'b1},
      '{'{16'd65535, 26'sd0, 26'sd0, 18'sd65536, 18'sd0}, 1'b0},
      '{'{16'd65535, 26'sd23592960, 26'sd0, 18'sd0, 18'sd65536}, 1'b0},
      '{'{16'd65535, -26'sd23592960, 26'sd0, -18'sd65536, 18'sd0}, 1'b0},
      '{'{16'd32768, 26'sd11796480, 26'sd0, 18'sd65536, 18'sd0}, 1'b0},
      '{'{16'd65535, 26'sd23592960, 26'sd23592960, 18'sd0, 18'sd0}, 1'b0},
      '{'{16'd65535, 26'sd0, -26'sd23592960, 18'sd65536, -18'sd65536}, 1'b0},
      '{'{16'd16384, 26'sd5898240, 26'sd5898240, -18'sd65536, 18'sd65536}, 1'b0},
      '{'{16'd1, 26'sd1, -26'sd1, 18'sd1, -18'sd1}, 1'b0},
      '{'{16'd65535, 26'sd23592960, 26'sd0, 18'sd0, 18'sd0}, 1'b0},
      '{'{16'd43690, 26'sd11796480, -26'sd11796480, 18'sd65536, 18'sd65536}, 1'b0},
      '{'{16'd0, -26'sd23592960, 26'sd23592960, -18'sd65536, -18'sd65536}, 1'b0},
      '{'{16'd49152, -26'sd7864320, 26'sd3932160, -18'sd32768, 18'sd49152}, 1'b0}};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [263:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [23:0]  csr_data = '0;

   euler_camera_motion_update dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data));

   always #4 clock = ~clock;

   // Predictor state.
   longint speed_q16;
   longint yaw_acc, pitch_acc;
   longint cam_pos [3];

   camera_view_t pending_views [$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  calm = 1'b0;   // no idling on either side while set

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint unit_clip(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint unit_mul(longint a, longint b);
      return unit_clip(round_shift(a * b, 14));
   endfunction

   function automatic longint pos_sat(longint v);
      if (v > PosTop) return PosTop;
      if (v < PosBottom) return PosBottom;
      return v;
   endfunction

   // Sine and cosine of an angle in 1/65536 degree, Q1.14.
   function automatic void angle_sin_cos(input longint ang, output longint sn, output longint cs);
      bit     flip;
      longint x, y, z, t;
      flip = 1'b0;
      x = Gain30;
      y = 0;
      if (ang > TurnHalf) ang -= TurnFull;
      if (ang > TurnQuarter) begin
         ang -= TurnHalf;
         flip = 1'b1;
      end else if (ang < -TurnQuarter) begin
         ang += TurnHalf;
         flip = 1'b1;
      end
      z = ang;
      for (int i = 0; i < Iterations; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= ArcTable[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += ArcTable[i];
         end
         x = t;
      end
      x = unit_clip(round_shift(x, 16));
      y = unit_clip(round_shift(y, 16));
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic camera_view_t advance_camera(tick_t tk);
      camera_view_t r;
      longint dt, sy, cy, sp, cp, sf, ss;
      longint v [9];
      dt = longint'(tk.dt);
      yaw_acc = (yaw_acc + ((longint'(tk.yaw_rate) * dt) >>> 16)) % TurnFull;
      if (yaw_acc < 0) yaw_acc += TurnFull;
      pitch_acc += (longint'(tk.pitch_rate) * dt) >>> 16;
      if (pitch_acc > PitchClamp) pitch_acc = PitchClamp;
      if (pitch_acc < -PitchClamp) pitch_acc = -PitchClamp;
      angle_sin_cos(yaw_acc, sy, cy);
      angle_sin_cos(pitch_acc, sp, cp);
      v[0] = unit_mul(cy, cp);  v[1] = sp;  v[2] = unit_mul(sy, cp);
      v[3] = -sy;               v[4] = 0;   v[5] = cy;
      v[6] = -unit_mul(cy, sp); v[7] = cp;  v[8] = -unit_mul(sy, sp);
      sf = round_shift(round_shift(longint'(tk.fwd_amt) * speed_q16, 16) * dt, 16);
      ss = round_shift(round_shift(longint'(tk.side_amt) * speed_q16, 16) * dt, 16);
      for (int k = 0; k < 3; k++) begin
         cam_pos[k] = pos_sat(cam_pos[k] + round_shift(sf * v[k], 14)
                              + round_shift(ss * v[3 + k], 14));
         r.pos[k] = cam_pos[k][39:0];
      end
      for (int k = 0; k < 9; k++) r.vec[k] = v[k][15:0];
      return r;
   endfunction

   function automatic tick_t random_tick();
      tick_t tk;
      int    mode;
      mode = $urandom_range(0, 9);
      tk.dt = (mode == 0) ? 16'd0 : (mode == 1) ? 16'hFFFF : 16'($urandom);
      if (mode == 2) begin
         tk.yaw_rate   = $urandom_range(0, 1) ? 26'sd23592960 : -26'sd23592960;
         tk.pitch_rate = $urandom_range(0, 1) ? 26'sd23592960 : -26'sd23592960;
         tk.fwd_amt    = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
         tk.side_amt   = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
      end else begin
         tk.yaw_rate   = 26'(longint'($urandom_range(0, 47185920)) - TurnFull);
         tk.pitch_rate = 26'(longint'($urandom_range(0, 47185920)) - TurnFull);
         tk.fwd_amt    = 18'(longint'($urandom_range(0, 131072)) - 65536);
         tk.side_amt   = 18'(longint'($urandom_range(0, 131072)) - 65536);
      end
      return tk;
   endfunction

   task automatic send_tick(tick_t tk, bit at_origin);
      camera_view_t exp_view;
      req_tdata  <= {8'd0, tk.side_amt, tk.fwd_amt, tk.pitch_rate, tk.yaw_rate, tk.dt};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp_view = advance_camera(tk);
      if (at_origin) for (int k = 0; k < 3; k++) exp_view.pos[k] = '0;
      pending_views.push_back(exp_view);
      if (!calm && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_speed(logic [23:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      speed_q16 = longint'(value);
   endtask

   // The block is idle once every result is back and its pipeline has drained.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_views.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      camera_view_t exp_view;
      logic signed [39:0] got_pos;
      logic signed [15:0] got_vec;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_views.size() == 0) begin
               $display("%0t: result transfer with nothing expected, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               exp_view = pending_views.pop_front();
               for (int k = 0; k < 3; k++) begin
                  got_pos = rsp_tdata[40 * k +: 40];
                  if (got_pos !== exp_view.pos[k]) begin
                     $display("%0t: position %0d expected %0d actual %0d",
                              $time, k, exp_view.pos[k], got_pos);
                     mismatches++;
                  end
               end
               for (int k = 0; k < 9; k++) begin
                  got_vec = rsp_tdata[120 + 16 * k +: 16];
                  if (got_vec !== exp_view.vec[k]) begin
                     $display("%0t: vector field %0d expected %0d actual %0d",
                              $time, k, exp_view.vec[k], got_vec);
                     mismatches++;
                  end
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 33);
      end
   end

   initial begin
      logic [23:0] speeds [4];
      speed_q16 = longint'(SpeedReset);
      yaw_acc = 0;
      pitch_acc = 0;
      for (int k = 0; k < 3; k++) cam_pos[k] = 0;
      speeds[0] = 24'd0;
      speeds[1] = 24'hFFFFFF;
      speeds[2] = 24'($urandom);
      speeds[3] = 24'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NumDirected; r++) send_tick(DIRECTED[r].tick, DIRECTED[r].at_origin);
      for (int n = 0; n < RandomPerPhase; n++) send_tick(random_tick(), 1'b0);

      for (int p = 0; p < 4; p++) begin
         drain();
         write_speed(speeds[p]);
         calm = (p == 2);
         for (int n = 0; n < RandomPerPhase; n++) send_tick(random_tick(), 1'b0);
         calm = 1'b0;
      end

      drain();
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/ecmu_pkg.sv
design/ecmu_cordic.sv
design/euler_camera_motion_update.sv
sim/euler_camera_motion_update_tb.sv
